// ----- hdl/iptlu_pkg.sv -----
// ----------------------------------------------------------------------------
// iptlu_pkg: shared definitions for the IPv4 trie prefix lookup
// Operation codes, port widths, parameter defaults and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package iptlu_pkg;

    // Parameter defaults.
    localparam int NODE_COUNT_DEF = 4096;
    localparam int VALUE_BITS_DEF = 16;
    localparam int ADDR_BITS_DEF  = 32;

    // Fixed field widths on the ports.
    localparam int OP_W        = 2;
    localparam int ADDR_W      = 32;
    localparam int MASK_W      = 32;
    localparam int VALUE_W     = 16;
    localparam int IN_TDATA_W  = ADDR_W + MASK_W + VALUE_W;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;

    // Bit offsets of the fields in the input tdata.
    localparam int ADDR_LSB  = 0;
    localparam int MASK_LSB  = ADDR_W;
    localparam int VALUE_LSB = ADDR_W + MASK_W;

    // Operation codes carried in the input tuser.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_LPM    = 2'd2;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted beat and start at the root
        logic sum;     // count the prefix length from the mask
        logic step;    // descend one trie level
        logic finish;  // apply the final action and load the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;      // the walk has reached its last node
        logic out_free;  // the result register can take a new result
    } dp_status_t;

endpackage

// ----- hdl/iptlu_ctrl.sv -----
// ----------------------------------------------------------------------------
// iptlu_ctrl: operation sequencer for the IPv4 trie prefix lookup
// Accepts one input beat at a time, runs the length count and the level
// walk in the datapath, and hands the result over once the output is free.
// ----------------------------------------------------------------------------
module iptlu_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  iptlu_pkg::dp_status_t  status,
    output iptlu_pkg::ctrl_cmd_t   cmd
);
    import iptlu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb
    begin
        cmd.load   = s_tvalid && ready_reg;
        cmd.sum    = (state_reg == ST_LEN);
        cmd.step   = (state_reg == ST_WALK) && !status.done;
        cmd.finish = (state_reg == ST_WALK) && status.done && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_LEN;
                    ready_next = 1'b0;
                end
            end
            ST_LEN:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (cmd.finish)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

// ----- hdl/iptlu_datapath.sv -----
// ----------------------------------------------------------------------------
// iptlu_datapath: node memory and walk logic for the IPv4 trie lookup
// Holds the node pool, the root entry, the allocation count, the per-item
// walk registers and the result register. One trie level per step.
// ----------------------------------------------------------------------------
module iptlu_datapath #(
    parameter int NODE_COUNT = iptlu_pkg::NODE_COUNT_DEF,
    parameter int VALUE_BITS = iptlu_pkg::VALUE_BITS_DEF,
    parameter int ADDR_BITS  = iptlu_pkg::ADDR_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  iptlu_pkg::ctrl_cmd_t               cmd,
    output iptlu_pkg::dp_status_t              status,
    input  logic [iptlu_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic [iptlu_pkg::OP_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [iptlu_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic [iptlu_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import iptlu_pkg::*;

    localparam int IW = $clog2(NODE_COUNT);
    localparam int UW = $clog2(NODE_COUNT + 1);
    localparam int LW = $clog2(ADDR_BITS + 1);
    localparam int VB = VALUE_BITS;
    localparam int EW = 2 * IW + 1 + VB;

    typedef enum logic [1:0] {
        SRC_ROOT,
        SRC_MEM,
        SRC_NEW
    } src_t;

    // Node pool. Entry layout from the lowest bit: value, valid, child 0,
    // child 1. Entry 0 is unused; the root lives in flip-flops.
    logic [EW-1:0] node_mem [NODE_COUNT];
    logic [EW-1:0] rd_q_reg;

    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;
    logic          mem_re;
    logic [IW-1:0] mem_ra;

    // Persistent state.
    logic [UW-1:0] used_reg;
    logic [IW-1:0] root_c0_reg;
    logic [IW-1:0] root_c1_reg;
    logic          root_valid_reg;
    logic [VB-1:0] root_value_reg;

    // Per-item registers.
    logic [OP_W-1:0]      op_reg;
    logic [ADDR_BITS-1:0] addr_sh_reg;
    logic [ADDR_BITS-1:0] mask_reg;
    logic [VB-1:0]        value_reg;
    logic [LW-1:0]        len_reg;
    logic [LW-1:0]        level_reg;
    src_t                 src_reg;
    logic [IW-1:0]        cur_reg;
    logic                 best_valid_reg;
    logic [VB-1:0]        best_value_reg;

    // Result register.
    logic               out_valid_reg;
    logic               hit_reg;
    logic [VALUE_W-1:0] found_reg;
    logic               stat_reg;

    // Current node fields.
    logic [IW-1:0] d_c0;
    logic [IW-1:0] d_c1;
    logic          d_valid;
    logic [VB-1:0] d_value;

    logic          bit_sel;
    logic [IW-1:0] nxt;
    logic          nxt_none;
    logic          at_len;
    logic          at_end;
    logic          pool_full;
    logic [IW-1:0] new_idx;
    logic          walk_done;
    logic          alloc;
    logic          store;

    logic [VB+VALUE_W-1:0] value_in_ext;
    logic [VB-1:0]         value_in;
    logic                  res_hit;
    logic [VB-1:0]         res_value;
    logic                  res_stat;
    logic [VB+VALUE_W-1:0] res_value_ext;

    always_comb
    begin
        case (src_reg)
            SRC_ROOT:
            begin
                d_c0    = root_c0_reg;
                d_c1    = root_c1_reg;
                d_valid = root_valid_reg;
                d_value = root_value_reg;
            end
            SRC_MEM:
            begin
                d_value = rd_q_reg[VB-1:0];
                d_valid = rd_q_reg[VB];
                d_c0    = rd_q_reg[VB+1 +: IW];
                d_c1    = rd_q_reg[VB+1+IW +: IW];
            end
            default:
            begin
                d_c0    = '0;
                d_c1    = '0;
                d_valid = 1'b0;
                d_value = '0;
            end
        endcase
    end

    assign bit_sel   = addr_sh_reg[ADDR_BITS-1];
    assign nxt       = bit_sel ? d_c1 : d_c0;
    assign nxt_none  = (nxt == '0);
    assign at_len    = (level_reg == len_reg);
    assign at_end    = (level_reg == LW'(ADDR_BITS));
    assign pool_full = (used_reg == UW'(NODE_COUNT));
    assign new_idx   = used_reg[IW-1:0];

    always_comb
    begin
        case (op_reg)
            OP_INSERT: walk_done = at_len || (nxt_none && pool_full);
            OP_FIND:   walk_done = at_len || nxt_none;
            OP_LPM:    walk_done = at_end || nxt_none;
            default:   walk_done = 1'b1;
        endcase
    end

    assign status.done     = walk_done;
    assign status.out_free = !out_valid_reg || m_tready;

    assign alloc = cmd.step && (op_reg == OP_INSERT) && nxt_none;
    assign store = cmd.finish && (op_reg == OP_INSERT) && at_len;

    // Memory access: a read on every descent to an existing child, a write
    // when a parent gains a child or when an insert stores its value. An
    // insert that runs out of nodes still clears the node it allocated last.
    always_comb
    begin
        mem_re = cmd.step && !alloc;
        mem_ra = nxt;
        mem_we = 1'b0;
        mem_wa = cur_reg;
        mem_wd = {d_c1, d_c0, d_valid, d_value};
        if (alloc && (src_reg != SRC_ROOT))
        begin
            mem_we = 1'b1;
            mem_wd = bit_sel ? {new_idx, d_c0, d_valid, d_value}
                             : {d_c1, new_idx, d_valid, d_value};
        end
        else if (store && (src_reg != SRC_ROOT))
        begin
            mem_we = 1'b1;
            mem_wd = {d_c1, d_c0, 1'b1, value_reg};
        end
        else if (cmd.finish && (op_reg == OP_INSERT) && (src_reg == SRC_NEW))
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_q_reg <= node_mem[mem_ra];
        end
    end

    // Values wider or narrower than the 16-bit field both pass through here.
    assign value_in_ext = {{VB{1'b0}}, s_tdata[VALUE_LSB +: VALUE_W]};
    assign value_in     = value_in_ext[VB-1:0];

    always_comb
    begin
        res_hit   = 1'b0;
        res_value = '0;
        res_stat  = STATUS_OK;
        case (op_reg)
            OP_INSERT:
            begin
                res_stat = at_len ? STATUS_OK : STATUS_FULL;
            end
            OP_FIND:
            begin
                if (at_len && d_valid)
                begin
                    res_hit   = 1'b1;
                    res_value = d_value;
                end
            end
            OP_LPM:
            begin
                res_hit   = best_valid_reg || d_valid;
                res_value = d_valid ? d_value : best_value_reg;
            end
            default:
            begin
                res_hit = 1'b0;
            end
        endcase
    end

    assign res_value_ext = {{VALUE_W{1'b0}}, res_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= UW'(1);
            root_c0_reg    <= '0;
            root_c1_reg    <= '0;
            root_valid_reg <= 1'b0;
            root_value_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (alloc)
            begin
                used_reg <= used_reg + UW'(1);
                if (src_reg == SRC_ROOT)
                begin
                    if (bit_sel)
                    begin
                        root_c1_reg <= new_idx;
                    end
                    else
                    begin
                        root_c0_reg <= new_idx;
                    end
                end
            end
            if (store && (src_reg == SRC_ROOT))
            begin
                root_valid_reg <= 1'b1;
                root_value_reg <= value_reg;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg         <= s_tuser;
            addr_sh_reg    <= s_tdata[ADDR_LSB +: ADDR_BITS];
            mask_reg       <= s_tdata[MASK_LSB +: ADDR_BITS];
            value_reg      <= value_in;
            level_reg      <= '0;
            src_reg        <= SRC_ROOT;
            cur_reg        <= '0;
            best_valid_reg <= 1'b0;
            best_value_reg <= '0;
        end
        if (cmd.sum)
        begin
            len_reg <= LW'($countones(mask_reg));
        end
        if (cmd.step)
        begin
            level_reg   <= level_reg + LW'(1);
            addr_sh_reg <= addr_sh_reg << 1;
            if (alloc)
            begin
                src_reg <= SRC_NEW;
                cur_reg <= new_idx;
            end
            else
            begin
                src_reg <= SRC_MEM;
                cur_reg <= nxt;
            end
            // The deepest valued node seen so far wins.
            if (d_valid)
            begin
                best_valid_reg <= 1'b1;
                best_value_reg <= d_value;
            end
        end
        if (cmd.finish)
        begin
            hit_reg   <= res_hit;
            found_reg <= res_value_ext[VALUE_W-1:0];
            stat_reg  <= res_stat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = found_reg;
    assign m_tuser  = {stat_reg, hit_reg};

`ifndef SYNTHESIS
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg >= UW'(1)) && (used_reg <= UW'(NODE_COUNT)))
        else $error("allocation count out of range");

    a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("node memory read and write in the same cycle");

    a_write_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((mem_wa != '0) && (UW'(mem_wa) < used_reg)))
        else $error("write to a node that is not allocated");

    a_alloc_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> $past((op_reg == OP_INSERT) && cmd.step))
        else $error("node allocated outside an insert step");
`endif

endmodule

// ----- hdl/ipv4_trie_prefix_lookup.sv -----
// ----------------------------------------------------------------------------
// ipv4_trie_prefix_lookup: binary trie longest-prefix match for IPv4
// Insert, exact find and longest-prefix match over a one-bit-per-level trie
// kept in an on-chip node pool.
//
//   Channel | Direction | Beat contents
//   s_*     | in        | tdata: addr, mask, value; tuser: op
//   m_*     | out       | tdata: found_value; tuser: hit, status
//
// An item is accepted, has its prefix length counted, then walks the trie:
// to at most the prefix length for insert and find, and to the
// matched depth (up to ADDR_BITS) for longest-prefix match. The walk takes
// one level per cycle, set by the registered read of the node memory.
// Reset leaves only the root allocated with no element; no clearing pass.
// A result waiting on m_tready does not block the next accept; only the end
// of the following walk waits for the result register to drain.
// ----------------------------------------------------------------------------
module ipv4_trie_prefix_lookup #(
    parameter int NODE_COUNT = iptlu_pkg::NODE_COUNT_DEF,
    parameter int VALUE_BITS = iptlu_pkg::VALUE_BITS_DEF,
    parameter int ADDR_BITS  = iptlu_pkg::ADDR_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // addr [31:0], mask [63:32], value [79:64]
    input  logic [iptlu_pkg::IN_TDATA_W-1:0]   s_tdata,
    // op [1:0]
    input  logic [iptlu_pkg::OP_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // found_value [15:0]
    output logic [iptlu_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // hit [0], status [1]
    output logic [iptlu_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import iptlu_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    iptlu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    iptlu_datapath #(
        .NODE_COUNT (NODE_COUNT),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- test/trie_lookup_checker.sv -----
// ----------------------------------------------------------------------------
// trie_lookup_checker: result predictor and scoreboard for the trie lookup
// Watches both stream channels. Every accepted command beat is applied to a
// private copy of the trie, and the result it must produce is queued. Every
// accepted result beat is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module trie_lookup_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // addr [31:0], mask [63:32], value [79:64]
    input  logic [iptlu_pkg::IN_TDATA_W-1:0]  s_tdata,
    // op [1:0]
    input  logic [iptlu_pkg::OP_W-1:0]        s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // found_value [15:0]
    input  logic [iptlu_pkg::OUT_TDATA_W-1:0] m_tdata,
    // hit [0], status [1]
    input  logic [iptlu_pkg::OUT_TUSER_W-1:0] m_tuser,
    output int                                errors,
    output int                                pending
);
    import iptlu_pkg::*;

    localparam int NODES = NODE_COUNT_DEF;
    localparam int LEVELS = ADDR_BITS_DEF;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] found_value;
        logic               status;
    } lookup_result_t;

    // Node 0 is the root; its valid flag and value hold the zero-length prefix.
    int unsigned        child [NODES][2];
    logic               node_valid [NODES];
    logic [VALUE_W-1:0] node_value [NODES];
    int unsigned        nodes_taken;

    lookup_result_t     lookup_results_q [$];
    lookup_result_t     want;
    int                 fault_count;

    function automatic lookup_result_t walk_trie(
        input logic [OP_W-1:0]    op,
        input logic [ADDR_W-1:0]  addr,
        input logic [MASK_W-1:0]  mask,
        input logic [VALUE_W-1:0] value
    );
        lookup_result_t r;
        int unsigned    len;
        int unsigned    cur;
        int unsigned    nxt;
        int             i;
        logic           b;
        logic           ok;
        r = '0;
        len = $countones(mask);
        cur = 0;
        ok = 1'b1;
        case (op)
            OP_INSERT:
            begin
                for (i = 0; i < len; i++)
                begin
                    b = addr[LEVELS-1-i];
                    nxt = child[cur][b];
                    if (nxt == 0)
                    begin
                        if (nodes_taken >= NODES)
                        begin
                            ok = 1'b0;
                            break;
                        end
                        nxt = nodes_taken;
                        nodes_taken++;
                        child[nxt][0] = 0;
                        child[nxt][1] = 0;
                        node_valid[nxt] = 1'b0;
                        node_value[nxt] = '0;
                        child[cur][b] = nxt;
                    end
                    cur = nxt;
                end
                if (ok)
                begin
                    node_valid[cur] = 1'b1;
                    node_value[cur] = value;
                end
                else
                begin
                    r.status = STATUS_FULL;
                end
            end
            OP_FIND:
            begin
                for (i = 0; i < len; i++)
                begin
                    nxt = child[cur][addr[LEVELS-1-i]];
                    if (nxt == 0)
                    begin
                        ok = 1'b0;
                        break;
                    end
                    cur = nxt;
                end
                if (ok && node_valid[cur])
                begin
                    r.hit = 1'b1;
                    r.found_value = node_value[cur];
                end
            end
            OP_LPM:
            begin
                if (node_valid[0])
                begin
                    r.hit = 1'b1;
                    r.found_value = node_value[0];
                end
                for (i = 0; i < LEVELS; i++)
                begin
                    nxt = child[cur][addr[LEVELS-1-i]];
                    if (nxt == 0)
                        break;
                    cur = nxt;
                    if (node_valid[cur])
                    begin
                        r.hit = 1'b1;
                        r.found_value = node_value[cur];
                    end
                end
            end
            default:
            begin
                // An unknown operation leaves the trie alone and reports nothing.
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_taken = 1;
            child[0][0] = 0;
            child[0][1] = 0;
            node_valid[0] = 1'b0;
            node_value[0] = '0;
            lookup_results_q.delete();
            fault_count = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (lookup_results_q.size() == 0)
                begin
                    $error("result beat with no command outstanding: hit %0d value %0h status %0d",
                           m_tuser[0], m_tdata, m_tuser[1]);
                    fault_count++;
                end
                else
                begin
                    want = lookup_results_q.pop_front();
                    if (m_tuser[0] !== want.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", want.hit, m_tuser[0]);
                        fault_count++;
                    end
                    if (m_tdata !== want.found_value)
                    begin
                        $error("found_value: expected %0h, actual %0h",
                               want.found_value, m_tdata);
                        fault_count++;
                    end
                    if (m_tuser[1] !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser[1]);
                        fault_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                lookup_results_q.push_back(walk_trie(s_tuser,
                                                     s_tdata[ADDR_LSB +: ADDR_W],
                                                     s_tdata[MASK_LSB +: MASK_W],
                                                     s_tdata[VALUE_LSB +: VALUE_W]));
            end
            errors <= fault_count;
            pending <= lookup_results_q.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the IPv4 trie prefix lookup
// Drives a directed set of inserts and lookups covering the root prefix,
// overwrites, scattered masks, full-depth paths and unknown operations, then
// a long random mix built around remembered prefixes that also runs the node
// pool dry. Command beats come in bursts and the result side stalls in
// changing patterns. Checking is done by the checker placed beside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import iptlu_pkg::*;

    localparam int RANDOM_ITEMS = 1125;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        int                len;
    } route_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    int errors;
    int pending;
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_phase = 0;
    int stall_mode = 0;

    route_t known_routes [$];

    ipv4_trie_prefix_lookup u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    trie_lookup_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    always #5 clk = ~clk;

    // The result side switches between steady, random, periodic and sparse ready.
    always @(negedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_phase <= $urandom_range(20, 150);
        end
        else
        begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (stall_phase % 4 == 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    function automatic logic [MASK_W-1:0] prefix_mask(input int len);
        return (len == 0) ? '0 : ~32'h0 << (32 - len);
    endfunction

    // Entered and left at a falling edge; a new burst may open with a gap.
    task automatic send_item(
        input logic [OP_W-1:0]    op,
        input logic [ADDR_W-1:0]  addr,
        input logic [MASK_W-1:0]  mask,
        input logic [VALUE_W-1:0] value
    );
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata <= IN_TDATA_W'({$urandom, $urandom, $urandom});
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {value, mask, addr};
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic route_t pick_route();
        route_t r;
        if (known_routes.size() == 0)
        begin
            r.addr = $urandom;
            r.len = $urandom_range(0, 32);
        end
        else
        begin
            r = known_routes[$urandom_range(0, known_routes.size() - 1)];
        end
        return r;
    endfunction

    initial
    begin
        int               n;
        int               pick;
        int               len;
        route_t           base;
        logic [OP_W-1:0]  op;
        logic [ADDR_W-1:0] addr;
        logic [MASK_W-1:0] mask;
        logic [VALUE_W-1:0] value;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty trie, then the root prefix.
        send_item(OP_LPM, 32'h0000_0000, 32'h0000_0000, 16'h0000);
        send_item(OP_FIND, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF);
        send_item(OP_INSERT, 32'h1234_5678, 32'h0000_0000, 16'hFFFF);
        send_item(OP_FIND, 32'h0000_0000, 32'h0000_0000, 16'h0000);
        send_item(OP_LPM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
        // Nested prefixes and full-depth routes at both address extremes.
        send_item(OP_INSERT, 32'h0A00_0000, 32'hFF00_0000, 16'h0001);
        send_item(OP_INSERT, 32'h0A01_0000, 32'hFFFF_0000, 16'h0002);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
        send_item(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_LPM, 32'h0A01_0203, 32'h0000_0000, 16'h0000);
        send_item(OP_LPM, 32'h0A02_0000, 32'h0000_0000, 16'h0000);
        send_item(OP_LPM, 32'h0B00_0000, 32'h0000_0000, 16'h0000);
        send_item(OP_FIND, 32'h0A00_0000, 32'hFF00_0000, 16'h0000);
        // A path that is absent, and an interior node that holds no element.
        send_item(OP_FIND, 32'h0A00_0000, 32'hFFFF_0000, 16'h0000);
        send_item(OP_FIND, 32'h0A00_0000, 32'hFFF0_0000, 16'h0000);
        // A scattered mask counts only its set bits.
        send_item(OP_INSERT, 32'hC0A8_0000, 32'h0000_FFFF, 16'h1234);
        send_item(OP_FIND, 32'hC0A8_9999, 32'hFFFF_0000, 16'h0000);
        // Overwrite an existing prefix.
        send_item(OP_INSERT, 32'h0A00_0000, 32'hFF00_0000, 16'hBEEF);
        send_item(OP_LPM, 32'h0A99_0000, 32'h0000_0000, 16'h0000);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_LPM, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
        send_item(OP_FIND, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000);
        send_item(OP_LPM, 32'h0000_0001, 32'hFFFF_FFFF, 16'hFFFF);

        // Random mix; the fully random /32 inserts use up the node pool part way.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            value = VALUE_W'($urandom);
            if (pick < 5)
            begin
                op = OP_UNUSED;
                addr = $urandom;
                mask = $urandom;
            end
            else if (pick < 45)
            begin
                op = OP_INSERT;
                if (known_routes.size() == 0 || $urandom_range(0, 1) == 1)
                begin
                    addr = $urandom;
                    len = ($urandom_range(0, 1) == 1) ? 32 : $urandom_range(1, 31);
                end
                else
                begin
                    base = pick_route();
                    len = base.len + $urandom_range(0, 8);
                    if (len > 32)
                        len = 32;
                    addr = base.addr ^ ($urandom & ~prefix_mask(base.len));
                end
                mask = prefix_mask(len);
                base.addr = addr;
                base.len = len;
                known_routes.push_back(base);
                if (known_routes.size() > 64)
                    void'(known_routes.pop_front());
            end
            else if (pick < 70)
            begin
                op = OP_FIND;
                base = pick_route();
                addr = base.addr;
                len = ($urandom_range(0, 9) < 7) ? base.len : $urandom_range(0, 32);
                mask = prefix_mask(len);
            end
            else
            begin
                op = OP_LPM;
                base = pick_route();
                if ($urandom_range(0, 4) == 0)
                    addr = $urandom;
                else
                    addr = base.addr ^ ($urandom & ~prefix_mask(base.len));
                mask = $urandom;
            end
            // Now and then a scattered mask on an insert or a find.
            if ((op == OP_INSERT || op == OP_FIND) && $urandom_range(0, 9) == 0)
                mask = $urandom;
            send_item(op, addr, mask, value);
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
